[rtl/core/lpt_pkg.sv]
package lpt_pkg;

	// sizes
	localparam int MAX_TASKS   = 64;
	localparam int TASK_BITS   = 6;   // index into the task store
	localparam int CNT_BITS    = 7;   // task count, holds MAX_TASKS itself
	localparam int MAX_WORKERS = 16;
	localparam int WRK_BITS    = 4;   // worker number
	localparam int NW_BITS     = 5;   // worker count, holds MAX_WORKERS itself
	localparam int WORK_BITS   = 32;
	localparam int LOAD_BITS   = 38;  // accumulated load of one worker

	// register map, word index from paddr[2]
	localparam logic REG_NUM_WORKERS = 1'b0;
	localparam logic [NW_BITS-1:0] NUM_WORKERS_RST = 5'd1;

	// one stored task, kept sorted by descending (work, index)
	typedef struct packed {
		logic [WORK_BITS-1:0] work;
		logic [TASK_BITS-1:0] idx;
	} lpt_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_FETCH,
		ST_SCAN,
		ST_EMIT,
		ST_OUT
	} lpt_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;     // input item taken this cycle
		logic ins_step;   // one insertion step
		logic fetch;      // read next sorted task, start worker scan
		logic scan;       // one worker compare
		logic emit;       // load result register, update worker load
		logic pop;        // result taken downstream
		logic batch_end;  // clear count, overflow and loads
	} lpt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;       // store holds MAX_TASKS tasks
		logic ins_done;   // insertion finishes this cycle
		logic scan_done;  // all active workers compared
		logic last_task;  // current result is the last of the batch
		logic out_valid;  // result register occupied
	} lpt_sts_t;

endpackage

[rtl/core/lpt_ctrl.sv]
module lpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	input  logic                out_ready,
	input  lpt_pkg::lpt_sts_t   sts,
	output logic                in_ready,
	output lpt_pkg::lpt_cmd_t   cmd
);

	lpt_pkg::lpt_state_t state_q, state_d;
	logic last_q;

	// state register and batch-close flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpt_pkg::ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpt_pkg::ST_IDLE && in_valid) begin
				last_q <= in_last;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!sts.full) begin
						state_d = lpt_pkg::ST_INSERT;
					end else if (in_last) begin
						state_d = lpt_pkg::ST_FETCH;
					end
				end
			end
			lpt_pkg::ST_INSERT: begin
				if (sts.ins_done) begin
					state_d = last_q ? lpt_pkg::ST_FETCH : lpt_pkg::ST_IDLE;
				end
			end
			lpt_pkg::ST_FETCH: state_d = lpt_pkg::ST_SCAN;
			lpt_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = lpt_pkg::ST_EMIT;
				end
			end
			lpt_pkg::ST_EMIT: state_d = lpt_pkg::ST_OUT;
			lpt_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = sts.last_task ? lpt_pkg::ST_IDLE : lpt_pkg::ST_FETCH;
				end
			end
			default: state_d = lpt_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lpt_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			lpt_pkg::ST_INSERT: cmd.ins_step = 1'b1;
			lpt_pkg::ST_FETCH:  cmd.fetch = 1'b1;
			lpt_pkg::ST_SCAN:   cmd.scan = 1'b1;
			lpt_pkg::ST_EMIT:   cmd.emit = 1'b1;
			lpt_pkg::ST_OUT: begin
				cmd.pop       = out_ready;
				cmd.batch_end = out_ready && sts.last_task;
			end
			default: cmd = '0;
		endcase
	end

	// results only leave from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.out_valid |-> state_q == lpt_pkg::ST_OUT)
		else $error("result register valid outside output state");

	// a closing item arriving at a full store leads straight to scheduling
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpt_pkg::ST_IDLE && in_valid && in_last && sts.full)
		|=> state_q == lpt_pkg::ST_FETCH)
		else $error("full batch close did not start scheduling");

endmodule

[rtl/core/lpt_datapath.sv]
module lpt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpt_pkg::lpt_cmd_t                   cmd,
	input  logic [lpt_pkg::WORK_BITS-1:0]       in_work,
	input  logic [lpt_pkg::NW_BITS-1:0]         num_workers,
	output lpt_pkg::lpt_sts_t                   sts,
	output logic [lpt_pkg::TASK_BITS-1:0]       task_index,
	output logic [lpt_pkg::WORK_BITS-1:0]       task_work,
	output logic [lpt_pkg::WRK_BITS-1:0]        worker,
	output logic                                last_result,
	output logic                                dropped
);

	// sorted task store
	lpt_pkg::lpt_entry_t task_mem [lpt_pkg::MAX_TASKS];
	lpt_pkg::lpt_entry_t rd_q;
	lpt_pkg::lpt_entry_t wdata;
	logic                             we, re;
	logic [lpt_pkg::TASK_BITS-1:0]    waddr, raddr;

	logic [lpt_pkg::CNT_BITS-1:0]     count_q;
	logic                             overflow_q;
	logic [lpt_pkg::TASK_BITS-1:0]    j_q;
	logic [lpt_pkg::TASK_BITS-1:0]    new_idx_q;
	logic [lpt_pkg::WORK_BITS-1:0]    new_w_q;
	logic [lpt_pkg::TASK_BITS-1:0]    k_q;
	logic                             shift;
	logic                             full;

	logic [lpt_pkg::LOAD_BITS-1:0]    load_q [lpt_pkg::MAX_WORKERS];
	logic [lpt_pkg::NW_BITS-1:0]      nw_eff;
	logic [lpt_pkg::NW_BITS-1:0]      scan_i_q;
	logic [lpt_pkg::WRK_BITS-1:0]     best_q;
	logic [lpt_pkg::LOAD_BITS-1:0]    best_load_q;
	logic                             scan_done;
	logic                             last_task;

	logic                             out_valid_q;
	logic [lpt_pkg::TASK_BITS-1:0]    idx_out_q;
	logic [lpt_pkg::WORK_BITS-1:0]    work_out_q;
	logic [lpt_pkg::WRK_BITS-1:0]     worker_out_q;
	logic                             last_out_q;
	logic                             dropped_out_q;

	assign full      = (count_q == lpt_pkg::CNT_BITS'(lpt_pkg::MAX_TASKS));
	assign shift     = (j_q != '0) && (rd_q.work <= new_w_q);
	assign last_task = ({1'b0, k_q} == (count_q - lpt_pkg::CNT_BITS'(1)));

	// active worker count, zero means one, clamp at the maximum
	always_comb begin
		if (num_workers == '0) begin
			nw_eff = lpt_pkg::NW_BITS'(1);
		end else if (num_workers > lpt_pkg::NW_BITS'(lpt_pkg::MAX_WORKERS)) begin
			nw_eff = lpt_pkg::NW_BITS'(lpt_pkg::MAX_WORKERS);
		end else begin
			nw_eff = num_workers;
		end
	end

	assign scan_done = (scan_i_q >= nw_eff);

	// store port control: insertion walks down from the tail
	always_comb begin
		we    = cmd.ins_step;
		waddr = j_q;
		wdata = shift ? rd_q : lpt_pkg::lpt_entry_t'{work: new_w_q, idx: new_idx_q};
		re    = 1'b0;
		raddr = k_q;
		if (cmd.accept) begin
			re    = !full && (count_q != '0);
			raddr = count_q[lpt_pkg::TASK_BITS-1:0] - lpt_pkg::TASK_BITS'(1);
		end else if (cmd.ins_step) begin
			re    = shift && (j_q >= lpt_pkg::TASK_BITS'(2));
			raddr = j_q - lpt_pkg::TASK_BITS'(2);
		end else if (cmd.fetch) begin
			re    = 1'b1;
			raddr = k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			task_mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= task_mem[raddr];
		end
	end

	// batch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
			k_q        <= '0;
		end else begin
			if (cmd.accept) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + lpt_pkg::CNT_BITS'(1);
				end
			end
			if (cmd.pop) begin
				k_q <= k_q + lpt_pkg::TASK_BITS'(1);
			end
			if (cmd.batch_end) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
				k_q        <= '0;
			end
		end
	end

	// insertion position and the new task
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			j_q       <= count_q[lpt_pkg::TASK_BITS-1:0];
			new_idx_q <= count_q[lpt_pkg::TASK_BITS-1:0];
			new_w_q   <= in_work;
		end else if (cmd.ins_step && shift) begin
			j_q <= j_q - lpt_pkg::TASK_BITS'(1);
		end
	end

	// worker loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < lpt_pkg::MAX_WORKERS; w++) begin
				load_q[w] <= '0;
			end
		end else if (cmd.batch_end) begin
			for (int w = 0; w < lpt_pkg::MAX_WORKERS; w++) begin
				load_q[w] <= '0;
			end
		end else if (cmd.emit) begin
			load_q[best_q] <= best_load_q + lpt_pkg::LOAD_BITS'(rd_q.work);
		end
	end

	// least-loaded search, one worker per cycle, lowest number wins ties
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			scan_i_q    <= lpt_pkg::NW_BITS'(1);
			best_q      <= '0;
			best_load_q <= load_q[0];
		end else if (cmd.scan && !scan_done) begin
			scan_i_q <= scan_i_q + lpt_pkg::NW_BITS'(1);
			if (load_q[scan_i_q[lpt_pkg::WRK_BITS-1:0]] < best_load_q) begin
				best_q      <= scan_i_q[lpt_pkg::WRK_BITS-1:0];
				best_load_q <= load_q[scan_i_q[lpt_pkg::WRK_BITS-1:0]];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			idx_out_q     <= rd_q.idx;
			work_out_q    <= rd_q.work;
			worker_out_q  <= best_q;
			last_out_q    <= last_task;
			dropped_out_q <= overflow_q;
		end
	end

	assign sts.full      = full;
	assign sts.ins_done  = !shift;
	assign sts.scan_done = scan_done;
	assign sts.last_task = last_task;
	assign sts.out_valid = out_valid_q;

	assign task_index  = idx_out_q;
	assign task_work   = work_out_q;
	assign worker      = worker_out_q;
	assign last_result = last_out_q;
	assign dropped     = dropped_out_q;

	// store never holds more than capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lpt_pkg::CNT_BITS'(lpt_pkg::MAX_TASKS))
		else $error("task count above capacity");

	// chosen worker is one of the active ones
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> {1'b0, best_q} < nw_eff)
		else $error("task assigned to inactive worker");

	// a pending result always belongs to a non-empty batch
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> count_q != '0)
		else $error("result pending with empty batch");

	// every emit presents a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

[rtl/core/lpt_task_scheduler_core.sv]
// channel   dir  handshake         payload
// s_*       in   s_tvalid/s_tready s_tdata = work_amount, s_tlast = is_last
// m_*       out  m_tvalid/m_tready m_tdata = index, work, worker; m_tlast, m_tuser
// apb       in   psel/penable      num_workers at byte address 0
//
// loading a task walks the single port down the sorted task store, past
// every stored task with equal or smaller work
// each result comes from a search over the loads of the n active workers
// (num_workers, zero read as one, capped at 16), one compare per cycle,
// and then waits out any downstream stall
// s_tready is high only between batches and between loaded tasks
// reset clears task count, overflow flag and worker loads; no clearing pass
// a stall on m_tready holds the result and the whole block
module lpt_task_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] work_amount
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [5:0] task_index, [37:6] task_work, [41:38] worker
	output logic        m_tlast,
	output logic        m_tuser,   // [0] dropped
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [lpt_pkg::NW_BITS-1:0]    num_workers_q;
	lpt_pkg::lpt_cmd_t              cmd;
	lpt_pkg::lpt_sts_t              sts;
	logic [lpt_pkg::TASK_BITS-1:0]  task_index;
	logic [lpt_pkg::WORK_BITS-1:0]  task_work;
	logic [lpt_pkg::WRK_BITS-1:0]   worker;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_workers_q <= lpt_pkg::NUM_WORKERS_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == lpt_pkg::REG_NUM_WORKERS) begin
			num_workers_q <= pwdata[lpt_pkg::NW_BITS-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == lpt_pkg::REG_NUM_WORKERS) begin
			prdata = {{(32-lpt_pkg::NW_BITS){1'b0}}, num_workers_q};
		end else begin
			prdata = '0;
		end
	end

	lpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.sts       (sts),
		.in_ready  (s_tready),
		.cmd       (cmd)
	);

	lpt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_work     (s_tdata),
		.num_workers (num_workers_q),
		.sts         (sts),
		.task_index  (task_index),
		.task_work   (task_work),
		.worker      (worker),
		.last_result (m_tlast),
		.dropped     (m_tuser)
	);

	// result packing
	assign m_tvalid = sts.out_valid;
	assign m_tdata  = {6'b0, worker, task_work, task_index};

endmodule
